[hdl/obi_pkg.sv]
// Shared types and constants for the order book imbalance signal block.
// No dependencies; every other file in hdl/ imports this package.
package obi_pkg;

    localparam int INST_W     = 4;
    localparam int SIZE_W     = 24;
    localparam int WEIGHT_W   = 16;
    localparam int PROD_W     = WEIGHT_W + SIZE_W;
    localparam int ACC_W      = 43;
    localparam int TOT_W      = ACC_W + 1;
    localparam int REM_W      = ACC_W + 2;
    localparam int Q_W        = 16;
    localparam int IMB_W      = 17;
    localparam int CNT_W      = 8;
    localparam int DEC_W      = 2;
    localparam int NL_W       = 4;
    localparam int LVLC_W     = 5;
    localparam int WEIGHT_LEVELS = 8;
    localparam int DIV_STEPS  = Q_W;
    localparam int DIV_CNT_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [DEC_W-1:0] DEC_NONE = 2'd0;
    localparam logic [DEC_W-1:0] DEC_BUY  = 2'd1;
    localparam logic [DEC_W-1:0] DEC_SELL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_HIGH = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_PREP,
        ST_DIV,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic clear;
        logic prep;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic last_level;
        logic clr_last;
        logic out_free;
    } status_t;

endpackage

[hdl/obi_level_if.sv]
// Level request channel: one order book level per request.
// Depends on obi_pkg for field widths.
interface obi_level_if;
    import obi_pkg::*;

    logic              valid;
    logic              ready;
    logic [INST_W-1:0] instrument;
    logic [SIZE_W-1:0] bid_size;
    logic [SIZE_W-1:0] ask_size;
    logic              bid_present;
    logic              ask_present;
    logic              book_initializing;
    logic              holding_long;

    modport source (
        output valid, instrument, bid_size, ask_size,
               bid_present, ask_present, book_initializing, holding_long,
        input  ready
    );
    modport sink (
        input  valid, instrument, bid_size, ask_size,
               bid_present, ask_present, book_initializing, holding_long,
        output ready
    );
endinterface

[hdl/obi_signal_if.sv]
// Signal request channel: one trading decision per completed snapshot.
// Depends on obi_pkg for field widths.
interface obi_signal_if;
    import obi_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [INST_W-1:0]       signal_instrument;
    logic [DEC_W-1:0]        decision;
    logic signed [IMB_W-1:0] imbalance_value;
    logic [CNT_W-1:0]        run_count;

    modport source (
        output valid, signal_instrument, decision, imbalance_value, run_count,
        input  ready
    );
    modport sink (
        input  valid, signal_instrument, decision, imbalance_value, run_count,
        output ready
    );
endinterface

[hdl/obi_ctrl.sv]
// Sequencer for the imbalance block: table clear, level intake, divide, decide.
// Depends on obi_pkg; drives the datapath through cmd_t, watches status_t.
module obi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  obi_pkg::status_t status,
    output obi_pkg::cmd_t    cmd
);
    import obi_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clr_last)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.ready  = 1'b1;
                cmd.accept = status.in_valid;
                if (status.in_valid && status.last_level)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep     = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // hold the decision until the output register frees up
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    a_div_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_cnt_reg == DIV_LAST) |=> state_reg == ST_DECIDE)
        else $error("divide did not hand over to decide");

    a_prep_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PREP |=> (state_reg == ST_DIV && div_cnt_reg == '0))
        else $error("divide started with stale step count");

    a_mid_level_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !status.last_level) |=> state_reg == ST_RUN)
        else $error("left intake before the snapshot's last level");

endmodule

[hdl/obi_dp.sv]
// Datapath: config registers, weighted accumulators, restoring divider,
// persistence table memory and output register. Depends on obi_pkg and
// the obi_level_if / obi_signal_if channel interfaces.
module obi_dp #(
    parameter int MAX_LEVELS  = 8,
    parameter int INSTRUMENTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [obi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [obi_pkg::CFG_DATA_W-1:0] cfg_data,
    input  obi_pkg::cmd_t                  cmd,
    output obi_pkg::status_t               status,
    obi_level_if.sink                      book,
    obi_signal_if.source                   sig
);
    import obi_pkg::*;

    localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int SLOT_W    = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int INST_SPAN = 2 ** INST_W;

    // configuration
    logic [NL_W-1:0]         level_count_reg;
    logic signed [IMB_W-1:0] entry_thr_reg;
    logic signed [IMB_W-1:0] exit_thr_reg;
    logic [CNT_W-1:0]        persist_len_reg;
    logic [CFG_DATA_W-1:0]   weight_low_reg;
    logic [CFG_DATA_W-1:0]   weight_high_reg;

    // snapshot intake
    logic [LVL_W-1:0]  lvl_reg;
    logic [ACC_W-1:0]  bid_acc_reg, ask_acc_reg;
    logic [1:0]        top_reg;
    logic [INST_W-1:0] inst_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              init_reg, held_reg;

    // divider
    logic [TOT_W-1:0] total_reg;
    logic [REM_W-1:0] rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic             neg_reg, neutral_reg;

    // persistence table
    logic [CNT_W-1:0]  count_mem [INSTRUMENTS];
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic [SLOT_W-1:0] clr_addr_reg;

    // output register
    logic                    out_valid_reg;
    logic [INST_W-1:0]       out_inst_reg;
    logic [DEC_W-1:0]        out_dec_reg;
    logic signed [IMB_W-1:0] out_imb_reg;
    logic [CNT_W-1:0]        out_cnt_reg;

    logic [LVLC_W-1:0]   levels, lvl_ext;
    logic                last_level;
    logic [WEIGHT_W-1:0] weights [WEIGHT_LEVELS];
    logic [WEIGHT_W-1:0] weight;
    logic [PROD_W-1:0]   bid_prod, ask_prod;
    logic [ACC_W-1:0]    bid_base, ask_base;
    logic [SLOT_W-1:0]   slot_lut [INST_SPAN];
    logic [SLOT_W-1:0]   in_slot;
    logic                rem_ge;
    logic [REM_W-1:0]    rem_sub;
    logic signed [IMB_W-1:0] q_signed, imb;
    logic [CNT_W-1:0]    cnt_inc, cnt_new;
    logic [DEC_W-1:0]    dec_new;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [CNT_W-1:0]    mem_wdata;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= NL_W'(5);
            entry_thr_reg   <= '0;
            exit_thr_reg    <= '0;
            persist_len_reg <= CNT_W'(3);
            weight_low_reg  <= '0;
            weight_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEVEL_COUNT: level_count_reg <= cfg_data[NL_W-1:0];
                CFG_ENTRY_THR:   entry_thr_reg   <= $signed(cfg_data[IMB_W-1:0]);
                CFG_EXIT_THR:    exit_thr_reg    <= $signed(cfg_data[IMB_W-1:0]);
                CFG_PERSIST_LEN: persist_len_reg <= cfg_data[CNT_W-1:0];
                CFG_WEIGHT_LOW:  weight_low_reg  <= cfg_data;
                CFG_WEIGHT_HIGH: weight_high_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------- level intake ----------------
    always_comb
    begin
        if (level_count_reg == '0)
            levels = LVLC_W'(1);
        else if (LVLC_W'(level_count_reg) > LVLC_W'(MAX_LEVELS))
            levels = LVLC_W'(MAX_LEVELS);
        else
            levels = LVLC_W'(level_count_reg);
    end

    assign lvl_ext    = LVLC_W'(lvl_reg);
    assign last_level = (lvl_ext + LVLC_W'(1)) >= levels;

    always_comb
    begin
        for (int k = 0; k < WEIGHT_LEVELS / 2; k++)
        begin
            weights[k]                     = weight_low_reg[k*WEIGHT_W +: WEIGHT_W];
            weights[k + WEIGHT_LEVELS / 2] = weight_high_reg[k*WEIGHT_W +: WEIGHT_W];
        end
    end

    // levels past the packed weights contribute nothing
    assign weight = (lvl_ext < LVLC_W'(WEIGHT_LEVELS)) ? weights[lvl_ext[2:0]] : '0;

    assign bid_prod = PROD_W'(weight) * PROD_W'(book.bid_size);
    assign ask_prod = PROD_W'(weight) * PROD_W'(book.ask_size);
    assign bid_base = (lvl_reg == '0) ? '0 : bid_acc_reg;
    assign ask_base = (lvl_reg == '0) ? '0 : ask_acc_reg;

    always_comb
    begin
        for (int i = 0; i < INST_SPAN; i++)
            slot_lut[i] = SLOT_W'(i % INSTRUMENTS);
    end

    assign in_slot = slot_lut[book.instrument];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg     <= '0;
            bid_acc_reg <= '0;
            ask_acc_reg <= '0;
            top_reg     <= '0;
        end
        else if (cmd.accept)
        begin
            bid_acc_reg <= bid_base + ACC_W'(bid_prod);
            ask_acc_reg <= ask_base + ACC_W'(ask_prod);
            if (lvl_reg == '0)
                top_reg <= {book.ask_present, book.bid_present};
            if (last_level)
                lvl_reg <= '0;
            else
                lvl_reg <= lvl_reg + LVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && last_level)
        begin
            inst_reg <= book.instrument;
            slot_reg <= in_slot;
            init_reg <= book.book_initializing;
            held_reg <= book.holding_long;
        end
    end

    // ---------------- divider: one quotient bit per step ----------------
    assign rem_ge  = rem_reg >= REM_W'(total_reg);
    assign rem_sub = rem_ge ? rem_reg - REM_W'(total_reg) : rem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            total_reg   <= TOT_W'(bid_acc_reg) + TOT_W'(ask_acc_reg);
            neg_reg     <= ask_acc_reg > bid_acc_reg;
            rem_reg     <= (ask_acc_reg > bid_acc_reg) ? REM_W'(ask_acc_reg - bid_acc_reg)
                                                       : REM_W'(bid_acc_reg - ask_acc_reg);
            neutral_reg <= init_reg || (bid_acc_reg == '0 && ask_acc_reg == '0)
                           || (top_reg != 2'b11);
            q_reg       <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= {rem_sub[REM_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], rem_ge};
        end
    end

    // ---------------- decision ----------------
    assign q_signed = $signed({1'b0, q_reg});
    assign imb      = neutral_reg ? '0 : (neg_reg ? -q_signed : q_signed);
    assign cnt_inc  = (rd_cnt_reg == CNT_MAX) ? rd_cnt_reg : rd_cnt_reg + CNT_W'(1);

    always_comb
    begin
        dec_new = DEC_NONE;
        cnt_new = '0;
        if (imb > entry_thr_reg)
        begin
            cnt_new = cnt_inc;
            if (cnt_inc >= persist_len_reg)
            begin
                cnt_new = '0;
                if (!held_reg)
                    dec_new = DEC_BUY;
            end
        end
        if (held_reg && imb < exit_thr_reg)
        begin
            dec_new = DEC_SELL;
            cnt_new = '0;
        end
    end

    // ---------------- persistence table ----------------
    assign mem_we    = cmd.clear || cmd.emit;
    assign mem_waddr = cmd.clear ? clr_addr_reg : slot_reg;
    assign mem_wdata = cmd.clear ? '0 : cnt_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            count_mem[mem_waddr] <= mem_wdata;
        if (cmd.accept && last_level)
            rd_cnt_reg <= count_mem[in_slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear)
            clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (sig.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_inst_reg <= inst_reg;
            out_dec_reg  <= dec_new;
            out_imb_reg  <= imb;
            out_cnt_reg  <= cnt_new;
        end
    end

    assign sig.valid             = out_valid_reg;
    assign sig.signal_instrument = out_inst_reg;
    assign sig.decision          = out_dec_reg;
    assign sig.imbalance_value   = out_imb_reg;
    assign sig.run_count         = out_cnt_reg;

    assign book.ready = cmd.ready;

    assign status.in_valid   = book.valid;
    assign status.last_level = last_level;
    assign status.clr_last   = (clr_addr_reg == SLOT_W'(INSTRUMENTS - 1));
    assign status.out_free   = !out_valid_reg || sig.ready;

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || sig.ready))
        else $error("decision overwrote an untaken result");

    a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !neutral_reg) |-> q_reg <= Q_W'(32768))
        else $error("imbalance magnitude above one");

    a_no_intake_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (!book.ready && !sig.valid))
        else $error("traffic during table clear");

endmodule

[hdl/order_book_imbalance_signal.sv]
// Weighted order book imbalance signal. After reset the block clears its
// per-instrument persistence table, one entry a cycle, with book.ready low;
// configuration writes are taken throughout. Each level request is absorbed
// by the two weighted multiply-accumulate units. The last level of a snapshot
// also starts the imbalance division, a restoring divider producing one
// quotient bit a cycle. The snapshot then goes through a setup step, sixteen
// divide steps and a decide step that updates the table and loads the output
// register; the decide step waits while that register still holds an untaken
// result. A finished decision waits in that register without blocking
// intake of the next snapshot.
// Depends on obi_pkg, obi_level_if, obi_signal_if, obi_ctrl and obi_dp.
module order_book_imbalance_signal #(
    parameter int MAX_LEVELS  = 8,
    parameter int INSTRUMENTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [obi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [obi_pkg::CFG_DATA_W-1:0] cfg_data,
    obi_level_if.sink                      book,
    obi_signal_if.source                   sig
);
    import obi_pkg::*;

    cmd_t    cmd;
    status_t status;

    obi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    obi_dp #(
        .MAX_LEVELS  (MAX_LEVELS),
        .INSTRUMENTS (INSTRUMENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .book      (book),
        .sig       (sig)
    );

endmodule
